>>> rtl/core/spq_pkg.sv
// shared constants, codes and types for the sorted priority queue
package spq_pkg;

   // queue geometry
   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int RANK_W  = 16;
   localparam int DATA_W  = 32;
   localparam int KIND_W  = 2;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 5;

   // operation codes
   localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POP   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   // command broadcast to every cell of the row
   typedef struct packed {
      logic                     push;
      logic signed [RANK_W-1:0] rank;
      logic [DATA_W-1:0]        payload;
   } spq_cmd_type;

endpackage

>>> rtl/core/spq_cell.sv
// one cell of the sorted row: holds an entry, compares and shifts on push
module spq_cell
   import spq_pkg::*;
(
   input  logic                     clock,
   input  spq_cmd_type              cmd,
   input  logic                     occupied,
   input  logic                     prev_gt,
   input  logic signed [RANK_W-1:0] prev_rank,
   input  logic [DATA_W-1:0]        prev_payload,
   output logic                     gt,
   output logic signed [RANK_W-1:0] rank,
   output logic [DATA_W-1:0]        payload
);

   logic signed [RANK_W-1:0] rank_ff;
   logic signed [RANK_W-1:0] rank_in;
   logic [DATA_W-1:0]        payload_ff;
   logic [DATA_W-1:0]        payload_in;

   // held entry outranks the incoming one, so it stays in place
   assign gt = occupied && (rank_ff > cmd.rank);

   // keep, take the new entry, or take the neighbor's entry
   always_comb begin
      rank_in    = rank_ff;
      payload_in = payload_ff;
      if (cmd.push && !gt) begin
         if (prev_gt) begin
            rank_in    = cmd.rank;
            payload_in = cmd.payload;
         end else begin
            rank_in    = prev_rank;
            payload_in = prev_payload;
         end
      end
   end

   always_ff @(posedge clock) begin
      rank_ff    <= rank_in;
      payload_ff <= payload_in;
   end

   assign rank    = rank_ff;
   assign payload = payload_ff;

endmodule

>>> rtl/core/sorted_priority_queue.sv
// sorted priority queue: a row of compare-and-shift cells plus a result register
//
// channel   direction  fields
// req_      in         kind, in_rank, in_payload
// rsp_      out        status, out_payload, out_rank, entry_count, head_rank, is_empty
//
// One operation per cycle: a push compares against every cell at once and the
// row shifts in the same cycle; a pop reads the tail cell and drops the count.
// Each result sits in one output register; a new request is taken whenever that
// register is empty or being drained, so throughput is one item a cycle.
// Synchronous active-high reset empties the queue and the result register;
// cell contents are not reset.
module sorted_priority_queue
   import spq_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [KIND_W-1:0]         req_kind,
   input  logic signed [RANK_W-1:0]  req_in_rank,
   input  logic [DATA_W-1:0]         req_in_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [STAT_W-1:0]         rsp_status,
   output logic [DATA_W-1:0]         rsp_out_payload,
   output logic signed [RANK_W-1:0]  rsp_out_rank,
   output logic [COUNT_W-1:0]        rsp_entry_count,
   output logic signed [RANK_W-1:0]  rsp_head_rank,
   output logic                      rsp_is_empty
);

   logic                     req_xfer;
   logic                     full;
   logic                     empty;
   logic                     do_push;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic [CNT_W-1:0]         tail_cnt;
   logic [IDX_W-1:0]         tail_idx;
   spq_cmd_type              cmd;
   logic                     cell_gt      [DEPTH];
   logic signed [RANK_W-1:0] cell_rank    [DEPTH];
   logic [DATA_W-1:0]        cell_payload [DEPTH];

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [STAT_W-1:0]        status_ff;
   logic [STAT_W-1:0]        status_in;
   logic [DATA_W-1:0]        out_payload_ff;
   logic [DATA_W-1:0]        out_payload_in;
   logic signed [RANK_W-1:0] out_rank_ff;
   logic signed [RANK_W-1:0] out_rank_in;
   logic [CNT_W-1:0]         count_out_ff;
   logic signed [RANK_W-1:0] head_rank_ff;
   logic signed [RANK_W-1:0] head_rank_in;

   // request side handshake
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = req_xfer && (req_kind == KIND_PUSH) && !full;
   assign tail_cnt = count_ff - CNT_W'(1);
   assign tail_idx = tail_cnt[IDX_W-1:0];

   assign cmd.push    = do_push;
   assign cmd.rank    = req_in_rank;
   assign cmd.payload = req_in_payload;

   // row of cells, cell 0 holds the head
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         spq_cell u_cell (
            .clock        (clock),
            .cmd          (cmd),
            .occupied     (count_ff > CNT_W'(i)),
            .prev_gt      (1'b1),
            .prev_rank    (req_in_rank),
            .prev_payload (req_in_payload),
            .gt           (cell_gt[i]),
            .rank         (cell_rank[i]),
            .payload      (cell_payload[i])
         );
      end else begin : g_body
         spq_cell u_cell (
            .clock        (clock),
            .cmd          (cmd),
            .occupied     (count_ff > CNT_W'(i)),
            .prev_gt      (cell_gt[i-1]),
            .prev_rank    (cell_rank[i-1]),
            .prev_payload (cell_payload[i-1]),
            .gt           (cell_gt[i]),
            .rank         (cell_rank[i]),
            .payload      (cell_payload[i])
         );
      end
   end

   // count update and result fields
   always_comb begin
      count_in       = count_ff;
      status_in      = ST_OK;
      out_payload_in = '0;
      out_rank_in    = '0;
      if (req_xfer) begin
         unique case (req_kind)
            KIND_PUSH: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            KIND_POP: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  count_in       = tail_cnt;
                  out_payload_in = cell_payload[tail_idx];
                  out_rank_in    = cell_rank[tail_idx];
               end
            end
            KIND_CLEAR: count_in = '0;
            default:    count_in = count_ff;
         endcase
      end
   end

   // head after the operation: a push lands at the head unless cell 0 outranks it
   always_comb begin
      if (count_in == '0) begin
         head_rank_in = '0;
      end else if (do_push && !cell_gt[0]) begin
         head_rank_in = req_in_rank;
      end else begin
         head_rank_in = cell_rank[0];
      end
   end

   // result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload captured on each request transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         status_ff      <= status_in;
         out_payload_ff <= out_payload_in;
         out_rank_ff    <= out_rank_in;
         count_out_ff   <= count_in;
         head_rank_ff   <= head_rank_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_out_payload = out_payload_ff;
   assign rsp_out_rank    = out_rank_ff;
   assign rsp_entry_count = COUNT_W'(count_out_ff);
   assign rsp_head_rank   = head_rank_ff;
   assign rsp_is_empty    = (count_out_ff == '0);

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_xfer_result: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_valid_ff && (count_out_ff == count_ff))
      else $error("result missing or count mismatch after transfer");

   a_push_full: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_kind == KIND_PUSH) && full
      |=> (status_ff == ST_FULL) && $stable(count_ff))
      else $error("push on full queue not dropped");

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_kind == KIND_POP) && empty
      |=> (status_ff == ST_EMPTY) && (out_payload_ff == '0) && (out_rank_ff == '0))
      else $error("pop on empty queue returned data");

endmodule
